FILE: rtl/bmhq_pkg.sv
package bmhq_pkg;

  // queue depth and data width
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned VAL_W    = 32;

  // operation codes carried on in_tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // status codes carried on out_tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // operation broadcast to every cell in the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [VAL_W-1:0] val;
  } cell_op_t;

  // contents of one cell
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } slot_t;

endpackage

FILE: rtl/bmhq_cell.sv
module bmhq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  bmhq_pkg::cell_op_t op,
  input  bmhq_pkg::slot_t   left_slot,
  input  logic              left_gt,
  input  bmhq_pkg::slot_t   right_slot,
  output bmhq_pkg::slot_t   slot,
  output logic              gt
);

  logic                       vld_r, vld_nxt;
  logic [bmhq_pkg::VAL_W-1:0] val_r, val_nxt;

  // new value sorts ahead of this entry, or this cell is free
  assign gt = !vld_r || ($signed(op.val) < $signed(val_r));

  assign slot.vld = vld_r;
  assign slot.val = val_r;

  // insert shifts the tail right, remove shifts everything left
  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (op.ins && gt) begin
      if (left_gt) begin
        vld_nxt = left_slot.vld;
        val_nxt = left_slot.val;
      end else begin
        vld_nxt = 1'b1;
        val_nxt = op.val;
      end
    end else if (op.rem) begin
      vld_nxt = right_slot.vld;
      val_nxt = right_slot.val;
    end
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: rtl/binary_min_heap_queue.sv
// result: registered in the cycle after its input transaction is accepted
// throughput: one transaction per cycle unless the output stalls; every
//   operation runs in a sorted chain of CAPACITY compare-and-shift cells
// reset: rst_n synchronous active low empties the queue and the output slot
module binary_min_heap_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] min_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned N = bmhq_pkg::CAPACITY;

  bmhq_pkg::slot_t    cell_slot [N];
  logic               cell_gt   [N];
  bmhq_pkg::cell_op_t op;
  bmhq_pkg::slot_t    empty_slot;

  logic        accept;
  logic        is_full, is_empty;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  assign empty_slot = '0;
  assign is_full    = cell_slot[N-1].vld;
  assign is_empty   = !cell_slot[0].vld;

  // input transaction handshake
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // operation broadcast
  assign op.ins = accept && (in_tuser == bmhq_pkg::KIND_INSERT) && !is_full;
  assign op.rem = accept && (in_tuser == bmhq_pkg::KIND_REMOVE) && !is_empty;
  assign op.val = in_tdata;

  // chain of sorted cells, smallest at index zero
  for (genvar i = 0; i < N; i++) begin : g_cell
    bmhq_pkg::slot_t l_slot, r_slot;
    logic            l_gt;
    if (i == 0) begin : g_head
      assign l_slot = empty_slot;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_slot = cell_slot[i-1];
      assign l_gt   = cell_gt[i-1];
    end
    if (i == N-1) begin : g_tail
      assign r_slot = empty_slot;
    end else begin : g_body
      assign r_slot = cell_slot[i+1];
    end
    bmhq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .left_slot  (l_slot),
      .left_gt    (l_gt),
      .right_slot (r_slot),
      .slot       (cell_slot[i]),
      .gt         (cell_gt[i])
    );
  end

  // result formation
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = '0;
      out_status_nxt = bmhq_pkg::ST_OK;
      if (in_tuser == bmhq_pkg::KIND_INSERT) begin
        if (is_full) begin
          out_status_nxt = bmhq_pkg::ST_FULL;
        end
      end else begin
        if (is_empty) begin
          out_status_nxt = bmhq_pkg::ST_EMPTY;
        end else begin
          out_data_nxt = cell_slot[0].val;
        end
      end
    end
  end

  // output slot control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output slot payload
  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: rtl/bmhq_checker.sv
module bmhq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // every accepted transaction shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted transaction");

  // a failed operation carries zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != bmhq_pkg::ST_OK |-> out_tdata == '0)
    else $error("nonzero data with failure status");

  // a full flag only answers an insert
  a_full_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == bmhq_pkg::KIND_REMOVE
      |=> out_tuser != bmhq_pkg::ST_FULL)
    else $error("full status on remove");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);
